>>> design/rps_pkg.sv
// Package: shared types and constants of the ranging pair scheduler.
package rps_pkg;

  localparam int unsigned NodeCountDef  = 16;
  localparam int unsigned QueueDepthDef = 120;

  localparam logic [30:0] TimeoutRst = 31'd2000;
  localparam logic [7:0]  SamplesRst = 8'd8;

  typedef enum logic [2:0] {
    FUNC_ENQUEUE = 3'd0,
    FUNC_TICK    = 3'd1,
    FUNC_READY   = 3'd2,
    FUNC_RESULT  = 3'd3,
    FUNC_CLEAR   = 3'd4
  } func_e;

  typedef enum logic [3:0] {
    CMD_NONE       = 4'd0,
    CMD_ENQUEUED   = 4'd1,
    CMD_REJECTED   = 4'd2,
    CMD_WAKE       = 4'd3,
    CMD_GO         = 4'd4,
    CMD_STORE      = 4'd5,
    CMD_FAILED     = 4'd6,
    CMD_READY_TO   = 4'd7,
    CMD_RESULT_TO  = 4'd8,
    CMD_SOLVE      = 4'd9,
    CMD_UNEXPECTED = 4'd10
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE        = 2'd0,
    PH_WAIT_READY  = 2'd1,
    PH_WAIT_RESULT = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_SHIFT_RD,
    ST_SHIFT,
    ST_INSERT,
    ST_POP_RD,
    ST_POP,
    ST_OUT
  } state_e;

  localparam logic [1:0] RegTimeout = 2'd0;
  localparam logic [1:0] RegSamples = 2'd1;

endpackage

>>> design/ranging_pair_scheduler_core.sv
// Top level: ranging pair scheduler with a sorted pair ring in one memory.
//
// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tuser func; tdata nodes, priority, leaf, time, mask,
//                                     ready node, status, distance
// m_axis    out  tvalid/tready        tuser command; tdata pair, samples, distance, busy, queued
// apb       in   psel/penable/pready  pair_timeout_ms (0x0), samples_per_pair (0x4)
//
// One transaction at a time. Enqueue scans the ring one entry at a time (read, then
// compare), then shifts the tail one entry at a time (read, then write); a tick pops
// dead pairs one at a time (read, then pop). Other functions go straight to the
// result state. The ring port (one read, one write per cycle) sets the rate.
// The result register holds until taken; input is not accepted while it is full.
module ranging_pair_scheduler_core #(
  parameter int unsigned NODE_COUNT  = rps_pkg::NodeCountDef,
  parameter int unsigned QUEUE_DEPTH = rps_pkg::QueueDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // func[2:0]
  input  logic [2:0]   s_axis_tuser_i,
  // first_node[3:0], second_node[7:4], pair_priority[10:8], responder_leaf[11],
  // now_ms[43:12], dead_mask[59:44], ready_node[63:60], result_status[71:64],
  // distance_in[95:72]
  input  logic [95:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // command[3:0]
  output logic [3:0]   m_axis_tuser_o,
  // pair_initiator[3:0], pair_responder[7:4], go_samples[15:8],
  // distance_out[39:16], busy_res[40], queued[47:41]
  output logic [47:0]  m_axis_tdata_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import rps_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

  // input fields
  logic [2:0]  in_func;
  logic [3:0]  in_a, in_b, in_rnode;
  logic [2:0]  in_prio;
  logic        in_leaf;
  logic [31:0] in_now;
  logic [15:0] in_dead;
  logic [7:0]  in_status;
  logic [23:0] in_dist;

  logic [98:0] item_q, item_d;
  assign in_func   = item_q[2:0];
  assign in_a      = item_q[6:3];
  assign in_b      = item_q[10:7];
  assign in_prio   = item_q[13:11];
  assign in_leaf   = item_q[14];
  assign in_now    = item_q[46:15];
  assign in_dead   = item_q[62:47];
  assign in_rnode  = item_q[66:63];
  assign in_status = item_q[74:67];
  assign in_dist   = item_q[98:75];

  // configuration
  logic [30:0] timeout_q;
  logic [7:0]  samples_q;
  logic [1:0]  reg_idx;
  assign pready = 1'b1;
  assign reg_idx = {1'b0, paddr[2]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
      samples_q <= SamplesRst;
    end else if (psel && penable && pwrite) begin
      if (reg_idx == RegTimeout) timeout_q <= pwdata[30:0];
      else if (reg_idx == RegSamples) samples_q <= pwdata[7:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (reg_idx == RegTimeout) prdata = {1'b0, timeout_q};
    else if (reg_idx == RegSamples) prdata = {24'd0, samples_q};
  end

  // ring memory
  logic [10:0] mem [QUEUE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [10:0]   mem_wd, mem_rd;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd <= mem[mem_ra];
  end

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, base} + {1'b0, off};
    if (s >= {1'b0, DepthC}) s = s - {1'b0, DepthC};
    return s[AW-1:0];
  endfunction

  function automatic logic node_missing(logic [3:0] n, logic [15:0] m);
    return ({28'd0, n} >= NODE_COUNT) || m[n];
  endfunction

  state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d, idx_q, idx_d, at_q, at_d;
  logic          found_q, found_d;
  phase_e        phase_q, phase_d;
  logic [3:0]    cur_i_q, cur_i_d, cur_r_q, cur_r_d;
  logic [1:0]    rdy_q, rdy_d;
  logic [31:0]   start_q, start_d;
  logic          active_q, active_d;
  logic          ov_q, ov_d;
  logic [51:0]   out_q, out_d;

  logic [3:0]  cmd;
  logic [3:0]  o_pi, o_pr;
  logic [7:0]  o_smp;
  logic [23:0] o_dist;
  logic [31:0] elapsed;
  logic [1:0]  rdy_n;
  logic [3:0]  ex, ey;
  logic        fin;

  assign s_axis_tready_o = (state_q == ST_IDLE) && !ov_q;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tuser_o  = out_q[3:0];
  assign m_axis_tdata_o  = out_q[51:4];
  assign elapsed = in_now - start_q;
  assign ex = mem_rd[3:0];
  assign ey = mem_rd[7:4];

  always_comb begin
    state_d = state_q; head_d = head_q; count_d = count_q; idx_d = idx_q;
    at_d = at_q; found_d = found_q; phase_d = phase_q; cur_i_d = cur_i_q;
    cur_r_d = cur_r_q; rdy_d = rdy_q; start_d = start_q; active_d = active_q;
    item_d = item_q; out_d = out_q; ov_d = ov_q;
    mem_we = 1'b0; mem_wa = head_q; mem_wd = {in_prio, in_b, in_a}; mem_ra = head_q;
    cmd = CMD_NONE; o_pi = '0; o_pr = '0; o_smp = '0; o_dist = '0; fin = 1'b0;
    rdy_n = rdy_q;
    if (ov_q && m_axis_tready_i) ov_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i && !ov_q) begin
          item_d = {s_axis_tdata_i, s_axis_tuser_i};
          state_d = ST_OUT;
          case (s_axis_tuser_i)
            FUNC_ENQUEUE: begin
              idx_d = '0; at_d = count_q; found_d = 1'b0; state_d = ST_SCAN_RD;
            end
            FUNC_TICK: if (phase_q == PH_IDLE) state_d = ST_POP_RD;
            default: ;
          endcase
        end
      end
      ST_OUT: begin
        fin = 1'b1;
        case (in_func)
          FUNC_TICK: begin
            if (phase_q == PH_WAIT_READY) begin
              if (rdy_q == 2'b11) begin
                phase_d = PH_WAIT_RESULT; cmd = CMD_GO; o_pi = cur_i_q; o_pr = cur_r_q;
                o_smp = samples_q;
              end else if (elapsed > {1'b0, timeout_q}) begin
                phase_d = PH_IDLE; cmd = CMD_READY_TO; o_pi = cur_i_q; o_pr = cur_r_q;
              end
            end else if (phase_q == PH_WAIT_RESULT) begin
              if (elapsed > {timeout_q, 1'b0}) begin
                phase_d = PH_IDLE; cmd = CMD_RESULT_TO; o_pi = cur_i_q; o_pr = cur_r_q;
              end
            end else if (active_q) begin
              active_d = 1'b0; cmd = CMD_SOLVE;
            end
          end
          FUNC_READY: if (phase_q == PH_WAIT_READY) begin
            if (in_rnode == cur_i_q) rdy_n[0] = 1'b1;
            if (in_rnode == cur_r_q) rdy_n[1] = 1'b1;
            rdy_d = rdy_n;
            if (rdy_n == 2'b11) begin
              phase_d = PH_WAIT_RESULT; cmd = CMD_GO; o_pi = cur_i_q; o_pr = cur_r_q;
              o_smp = samples_q;
            end
          end
          FUNC_RESULT: begin
            if (phase_q != PH_WAIT_RESULT) cmd = CMD_UNEXPECTED;
            else begin
              o_pi = cur_i_q; o_pr = cur_r_q; phase_d = PH_IDLE;
              if (in_status == 8'd0 && !in_dist[23]) begin
                cmd = CMD_STORE; o_dist = in_dist;
              end else cmd = CMD_FAILED;
            end
          end
          FUNC_CLEAR: begin
            active_d = 1'b0; count_d = '0; phase_d = PH_IDLE;
          end
          default: ;
        endcase
      end
      ST_SCAN_RD: begin
        o_pi = in_a; o_pr = in_b;
        if (in_a == in_b || in_leaf || count_q >= DepthC) begin
          cmd = CMD_REJECTED; fin = 1'b1;
        end else if (idx_q == count_q) begin
          idx_d = count_q; state_d = ST_SHIFT_RD;
        end else begin
          mem_ra = wrap_add(head_q, idx_q); state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((ex == in_a && ey == in_b) || (ex == in_b && ey == in_a)) begin
          cmd = CMD_REJECTED; o_pi = in_a; o_pr = in_b; fin = 1'b1;
        end else begin
          if (!found_q && in_prio < mem_rd[10:8]) begin
            found_d = 1'b1; at_d = idx_q;
          end
          idx_d = idx_q + 1'b1; state_d = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (idx_q == at_q) state_d = ST_INSERT;
        else begin
          mem_ra = wrap_add(head_q, idx_q - 1'b1); state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        mem_we = 1'b1; mem_wa = wrap_add(head_q, idx_q); mem_wd = mem_rd;
        idx_d = idx_q - 1'b1; state_d = ST_SHIFT_RD;
      end
      ST_INSERT: begin
        mem_we = 1'b1; mem_wa = wrap_add(head_q, at_q);
        count_d = count_q + 1'b1; active_d = 1'b1;
        cmd = CMD_ENQUEUED; o_pi = in_a; o_pr = in_b; fin = 1'b1;
      end
      ST_POP_RD: begin
        if (count_q == '0) begin
          state_d = ST_OUT;
        end else begin
          mem_ra = head_q; state_d = ST_POP;
        end
      end
      ST_POP: begin
        head_d = wrap_add(head_q, CW'(1)); count_d = count_q - 1'b1;
        if (node_missing(ex, in_dead) || node_missing(ey, in_dead)) state_d = ST_POP_RD;
        else begin
          cur_i_d = ex; cur_r_d = ey; rdy_d = 2'b00; start_d = in_now;
          phase_d = PH_WAIT_READY; cmd = CMD_WAKE; o_pi = ex; o_pr = ey; fin = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (fin) begin
      state_d = ST_IDLE; ov_d = 1'b1;
      out_d = {7'(count_d), (active_d || phase_d != PH_IDLE), o_dist, o_smp,
               o_pr, o_pi, cmd};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; head_q <= '0; count_q <= '0; idx_q <= '0; at_q <= '0;
      found_q <= 1'b0; phase_q <= PH_IDLE; cur_i_q <= '0; cur_r_q <= '0;
      rdy_q <= '0; start_q <= '0; active_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; head_q <= head_d; count_q <= count_d; idx_q <= idx_d;
      at_q <= at_d; found_q <= found_d; phase_q <= phase_d; cur_i_q <= cur_i_d;
      cur_r_q <= cur_r_d; rdy_q <= rdy_d; start_q <= start_d; active_q <= active_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

endmodule

>>> tb/tb.sv
// Testbench for the ranging pair scheduler core: directed and random checks against a predictor.
`timescale 1ns / 1ps

module tb;
  import rps_pkg::*;

  localparam int unsigned Depth = QueueDepthDef;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  // func
  logic [2:0]   s_axis_tuser_i = '0;
  // first_node, second_node, pair_priority, responder_leaf, now_ms,
  // dead_mask, ready_node, result_status, distance_in
  logic [95:0]  s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // command
  logic [3:0]   m_axis_tuser_o;
  // pair_initiator, pair_responder, go_samples, distance_out, busy_res, queued
  logic [47:0]  m_axis_tdata_o;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  ranging_pair_scheduler_core dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // scheduler shadow state
  logic [10:0] ring [Depth];
  int unsigned ring_head, ring_count;
  phase_e      phase;
  logic [3:0]  cur_ini, cur_resp;
  logic [1:0]  rdy_flags;
  logic [31:0] start_ms;
  logic        active;
  logic [30:0] timeout_ms;
  logic [7:0]  samples;

  logic [51:0] cmd_q [$];
  int          errors = 0;
  int          n_items = 0;
  int          n_results = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  logic [31:0] now_ms = '0;

  function automatic bit pair_queued(logic [3:0] a, logic [3:0] b);
    logic [10:0] e;
    for (int i = 0; i < ring_count; i++) begin
      e = ring[(ring_head + i) % Depth];
      if ((e[3:0] == a && e[7:4] == b) || (e[3:0] == b && e[7:4] == a)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the shadow state by one transaction and return the packed result.
  function automatic logic [51:0] schedule_step(logic [98:0] d);
    func_e       fn;
    logic [3:0]  a, b, rn;
    logic [2:0]  pri;
    logic        leaf;
    logic [31:0] now, elapsed;
    logic [15:0] dead;
    logic [7:0]  status;
    logic [23:0] distance;
    cmd_e        cmd;
    logic [3:0]  pi, pr;
    logic [7:0]  smp;
    logic [23:0] dout;
    int unsigned at;
    logic [10:0] e;
    bit          started;
    fn = func_e'(d[2:0]); a = d[6:3]; b = d[10:7]; pri = d[13:11]; leaf = d[14];
    now = d[46:15]; dead = d[62:47]; rn = d[66:63]; status = d[74:67]; distance = d[98:75];
    cmd = CMD_NONE; pi = '0; pr = '0; smp = '0; dout = '0;
    elapsed = now - start_ms;
    case (fn)
      FUNC_ENQUEUE: begin
        pi = a; pr = b;
        if (a == b || leaf || pair_queued(a, b) || ring_count >= Depth) begin
          cmd = CMD_REJECTED;
        end else begin
          at = ring_count;
          for (int i = 0; i < ring_count; i++)
            if (pri < ring[(ring_head + i) % Depth][10:8]) begin
              at = i;
              break;
            end
          for (int i = ring_count; i > at; i--)
            ring[(ring_head + i) % Depth] = ring[(ring_head + i - 1) % Depth];
          ring[(ring_head + at) % Depth] = {pri, b, a};
          ring_count++;
          active = 1'b1;
          cmd = CMD_ENQUEUED;
        end
      end
      FUNC_TICK: begin
        if (phase == PH_IDLE) begin
          started = 1'b0;
          while (ring_count > 0) begin
            e = ring[ring_head];
            ring_head = (ring_head + 1) % Depth;
            ring_count--;
            if (dead[e[3:0]] || dead[e[7:4]]) continue;
            cur_ini = e[3:0]; cur_resp = e[7:4]; rdy_flags = '0;
            start_ms = now; phase = PH_WAIT_READY;
            cmd = CMD_WAKE; pi = cur_ini; pr = cur_resp;
            started = 1'b1;
            break;
          end
          if (!started && active) begin
            active = 1'b0;
            cmd = CMD_SOLVE;
          end
        end else if (phase == PH_WAIT_READY) begin
          if (rdy_flags == 2'b11) begin
            phase = PH_WAIT_RESULT;
            cmd = CMD_GO; pi = cur_ini; pr = cur_resp; smp = samples;
          end else if (elapsed > {1'b0, timeout_ms}) begin
            phase = PH_IDLE;
            cmd = CMD_READY_TO; pi = cur_ini; pr = cur_resp;
          end
        end else if (elapsed > {timeout_ms, 1'b0}) begin
          phase = PH_IDLE;
          cmd = CMD_RESULT_TO; pi = cur_ini; pr = cur_resp;
        end
      end
      FUNC_READY: begin
        if (phase == PH_WAIT_READY) begin
          if (rn == cur_ini) rdy_flags[0] = 1'b1;
          if (rn == cur_resp) rdy_flags[1] = 1'b1;
          if (rdy_flags == 2'b11) begin
            phase = PH_WAIT_RESULT;
            cmd = CMD_GO; pi = cur_ini; pr = cur_resp; smp = samples;
          end
        end
      end
      FUNC_RESULT: begin
        if (phase != PH_WAIT_RESULT) begin
          cmd = CMD_UNEXPECTED;
        end else begin
          pi = cur_ini; pr = cur_resp;
          if (status == 8'd0 && !distance[23]) begin
            cmd = CMD_STORE;
            dout = distance;
          end else begin
            cmd = CMD_FAILED;
          end
          phase = PH_IDLE;
        end
      end
      FUNC_CLEAR: begin
        active = 1'b0; ring_count = 0; phase = PH_IDLE;
      end
      default: ;
    endcase
    return {7'(ring_count), active || phase != PH_IDLE, dout, smp, pr, pi, cmd};
  endfunction

  function automatic logic [98:0] pack_item(func_e fn, logic [3:0] a = 0, logic [3:0] b = 0,
                                            logic [2:0] pri = 0, logic leaf = 0,
                                            logic [31:0] now = 0, logic [15:0] dead = 0,
                                            logic [3:0] rn = 0, logic [7:0] status = 0,
                                            logic [23:0] distance = 0);
    return {distance, status, rn, dead, now, leaf, pri, b, a, fn};
  endfunction

  task automatic send_item(logic [98:0] d);
    if (!quiet && $urandom_range(2) == 0) repeat ($urandom_range(1, 16)) @(negedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= d[2:0];
    s_axis_tdata_i  <= d[98:3];
    do @(posedge clk_i); while (!s_axis_tready_o);
    cmd_q.push_back(schedule_step(d));
    n_items++;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic send_op(func_e fn, logic [3:0] a = 0, logic [3:0] b = 0, logic [2:0] pri = 0,
                         logic leaf = 0, logic [15:0] dead = 0, logic [3:0] rn = 0,
                         logic [7:0] status = 0, logic [23:0] distance = 0);
    send_item(pack_item(fn, a, b, pri, leaf, now_ms, dead, rn, status, distance));
  endtask

  task automatic drain();
    wait (cmd_q.size() == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx[0], 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == RegTimeout) timeout_ms = val[30:0];
    else if (idx == RegSamples) samples = val[7:0];
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      m_axis_tready_i <= 1'b0;
      repeat (3000) @(negedge clk_i);
      hold_req = 1'b0;
    end else if (quiet || $urandom_range(1) == 0) begin
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
    end else begin
      m_axis_tready_i <= 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    logic [51:0] want;
    logic [51:0] got;
    got = {m_axis_tdata_o, m_axis_tuser_o};
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_results++;
      if (cmd_q.size() == 0) begin
        $error("result with no expectation: %h", got);
        errors++;
      end else begin
        want = cmd_q.pop_front();
        if (got[3:0] != want[3:0]) begin
          $error("command: expected %0d, got %0d", want[3:0], got[3:0]); errors++;
        end
        if (got[7:4] != want[7:4]) begin
          $error("pair_initiator: expected %0d, got %0d", want[7:4], got[7:4]);
          errors++;
        end
        if (got[11:8] != want[11:8]) begin
          $error("pair_responder: expected %0d, got %0d", want[11:8], got[11:8]);
          errors++;
        end
        if (got[19:12] != want[19:12]) begin
          $error("go_samples: expected %0d, got %0d", want[19:12], got[19:12]);
          errors++;
        end
        if (got[43:20] != want[43:20]) begin
          $error("distance_out: expected %h, got %h", want[43:20], got[43:20]);
          errors++;
        end
        if (got[44] != want[44]) begin
          $error("busy_res: expected %0d, got %0d", want[44], got[44]); errors++;
        end
        if (got[51:45] != want[51:45]) begin
          $error("queued: expected %0d, got %0d", want[51:45], got[51:45]);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_op(FUNC_TICK);                              // nothing to do
    send_op(FUNC_RESULT, .status(0), .distance(24'h000100)); // result while idle
    send_op(FUNC_READY, .rn(4'd3));                  // ready while idle
    send_op(FUNC_ENQUEUE, 4'd5, 4'd5, 3'd1);         // same node
    send_op(FUNC_ENQUEUE, 4'd1, 4'd2, 3'd1, 1'b1);   // leaf responder
    send_op(FUNC_ENQUEUE, 4'd0, 4'd15, 3'd7);
    send_op(FUNC_ENQUEUE, 4'd15, 4'd0, 3'd0);        // reversed duplicate
    send_op(FUNC_ENQUEUE, 4'd1, 4'd2, 3'd0);
    send_op(FUNC_ENQUEUE, 4'd3, 4'd4, 3'd0);         // same priority goes after
    send_op(FUNC_ENQUEUE, 4'd6, 4'd7, 3'd3);
    send_op(FUNC_TICK, .dead(16'h0002));             // drop 1-2, wake 3-4
    send_op(FUNC_READY, .rn(4'd9));                  // outside the pair
    send_op(FUNC_READY, .rn(4'd3));
    send_op(FUNC_RESULT);                            // not yet waiting for result
    send_op(FUNC_READY, .rn(4'd4));                  // go
    send_op(FUNC_RESULT, .status(0), .distance(24'h7FFFFF));
    send_op(FUNC_TICK);                              // wake 6-7
    send_op(FUNC_READY, .rn(4'd6));
    send_op(FUNC_READY, .rn(4'd7));
    send_op(FUNC_RESULT, .status(0), .distance(24'h800000)); // negative distance fails
    send_op(FUNC_TICK, .dead(16'h8000));             // drop 0-15, solve
    send_op(FUNC_TICK);
    send_item(pack_item(func_e'(3'd7)));             // unused code
    send_op(FUNC_ENQUEUE, 4'd8, 4'd9, 3'd2);
    send_op(FUNC_CLEAR);
  endtask

  task automatic test_timeouts();
    write_reg(RegTimeout, 32'hFFFF_FFFF);            // top bit dropped
    write_reg(RegSamples, 32'h0000_00FF);
    now_ms = 32'hFFFF_FFF0;
    send_op(FUNC_ENQUEUE, 4'd2, 4'd11, 3'd5);
    send_op(FUNC_TICK);
    now_ms = 32'h7FFF_FFEF;                          // elapsed equals the limit: no timeout
    send_op(FUNC_TICK);
    now_ms = 32'h7FFF_FFF0;
    send_op(FUNC_TICK);                              // ready timeout across the wrap
    write_reg(RegTimeout, 32'd0);
    write_reg(RegSamples, 32'd0);
    send_op(FUNC_ENQUEUE, 4'd2, 4'd11, 3'd5);
    send_op(FUNC_TICK);
    send_op(FUNC_READY, .rn(4'd11));
    send_op(FUNC_READY, .rn(4'd2));
    send_op(FUNC_TICK);                              // same ms: no timeout
    now_ms++;
    send_op(FUNC_TICK);                              // result timeout
    send_op(FUNC_RESULT, .status(8'hFF));
    write_reg(RegTimeout, 32'd2000);
    write_reg(RegSamples, 32'd8);
  endtask

  // every unordered pair of 16 nodes exactly fills the ring; receiver held off at the start
  task automatic test_full_ring();
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++)
      for (int j = i + 1; j < 16; j++)
        send_op(FUNC_ENQUEUE, 4'(i), 4'(j), 3'($urandom_range(7)));
    send_op(FUNC_ENQUEUE, 4'd3, 4'd12, 3'd0);        // duplicate, ring full
    send_op(FUNC_TICK, .dead(16'hFFFE));             // pops many dead pairs
    send_op(FUNC_ENQUEUE, 4'd14, 4'd13, 3'd0);
    send_op(FUNC_CLEAR);
    send_op(FUNC_TICK);
  endtask

  task automatic test_random(int count, logic [30:0] tmo);
    int unsigned r;
    logic [3:0]  a, b;
    write_reg(RegTimeout, {1'b0, tmo});
    write_reg(RegSamples, $urandom);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if ($urandom_range(19) == 0) now_ms = $urandom;
      else now_ms += $urandom_range(0, 2 * tmo + 2);
      a = 4'($urandom); b = 4'($urandom);
      if (phase == PH_WAIT_READY && r < 45) begin
        send_op(FUNC_READY, .rn(r < 20 ? cur_ini : r < 40 ? cur_resp : 4'($urandom)));
      end else if (phase == PH_WAIT_RESULT && r < 45) begin
        send_op(FUNC_RESULT, .status(r < 35 ? 8'd0 : 8'($urandom)),
                .distance(24'($urandom)));
      end else if (r < 60) begin
        send_op(FUNC_ENQUEUE, a, b, 3'($urandom), $urandom_range(9) == 0);
      end else if (r < 90) begin
        send_op(FUNC_TICK, .dead($urandom_range(3) == 0 ? 16'($urandom) : 16'd0));
      end else if (r < 93) begin
        send_item(pack_item(func_e'(3'($urandom_range(5, 7))), a, b, 3'($urandom),
                            1'($urandom), $urandom, 16'($urandom), 4'($urandom),
                            8'($urandom), 24'($urandom)));
      end else if (r < 95) begin
        send_op(FUNC_CLEAR);
      end else begin
        send_item(pack_item(func_e'(3'($urandom_range(0, 4))), a, b, 3'($urandom),
                            1'($urandom), $urandom, 16'($urandom), 4'($urandom),
                            8'($urandom), 24'($urandom)));
      end
    end
  endtask

  initial begin
    ring_head = 0; ring_count = 0; phase = PH_IDLE; cur_ini = '0; cur_resp = '0;
    rdy_flags = '0; start_ms = '0; active = 1'b0; timeout_ms = TimeoutRst;
    samples = SamplesRst;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_timeouts();
    test_full_ring();
    test_random(300, 31'd100);
    test_random(200, 31'd0);
    test_random(180, 31'd20);
    quiet = 1'b1;
    test_random(100, 31'd50);
    wait (cmd_q.size() == 0);
    repeat (600) @(negedge clk_i);
    $display("Covered %0d transactions and %0d results: rejects, full ring, dead pairs,",
             n_items, n_results);
    $display("ready and result timeouts, stores, failures and clears under four settings.");
    if (errors == 0 && cmd_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
design/rps_pkg.sv
design/ranging_pair_scheduler_core.sv
tb/tb.sv
